/* design/tbs_pkg.sv */
// ----------------------------------------------------------------------------
// tbs_pkg: shared types and constants of the texture sampler
// Holds the queue entry between the front and back parts and fixed widths.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int unsigned IDX_W    = 12;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH = 16;

  typedef enum logic {
    CFG_TEX_WIDTH  = 1'b0,
    CFG_TEX_HEIGHT = 1'b1
  } cfg_index_e;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  typedef struct packed {
    logic              is_sample;
    logic [7:0]        texel_x;
    logic [7:0]        texel_y;
    logic [23:0]       texel_rgb;
    logic [IDX_W-1:0]  iu;
    logic [IDX_W-1:0]  iv;
    logic [15:0]       tu;
    logic [15:0]       tv;
    logic [47:0]       shade;
  } entry_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } result_t;

endpackage

/* design/tbs_ram.sv */
// ----------------------------------------------------------------------------
// tbs_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tbs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tbs_fifo.sv */
// ----------------------------------------------------------------------------
// tbs_fifo: small register queue
// Decouples two parts of the sampler; data is read from the head in place.
// ----------------------------------------------------------------------------
module tbs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign count_o = count_q;

endmodule

/* design/tbs_front.sv */
// ----------------------------------------------------------------------------
// tbs_front: input stage of the texture sampler
// Accepts transactions, clamps the texture size and forms texel indices and
// blend weights for samples before handing entries to the queue.
// ----------------------------------------------------------------------------
module tbs_front
  import tbs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             func_i,
  input  logic [7:0]       texel_x_i,
  input  logic [7:0]       texel_y_i,
  input  logic [7:0]       texel_red_i,
  input  logic [7:0]       texel_green_i,
  input  logic [7:0]       texel_blue_i,
  input  logic [23:0]      u_coord_i,
  input  logic [23:0]      v_coord_i,
  input  logic [15:0]      shade_red_i,
  input  logic [15:0]      shade_green_i,
  input  logic [15:0]      shade_blue_i,
  input  logic [CFG_W-1:0] tex_width_i,
  input  logic [CFG_W-1:0] tex_height_i,
  input  logic             q_full_i,
  output logic             push_o,
  output entry_t           entry_o
);

  logic              valid_q, valid_d;
  entry_t            entry_q;
  logic              accept;
  logic [SIZE_W-1:0] w_ext, h_ext, w_cl, h_cl, w_m3, h_m3;
  logic [28:0]       su, sv;

  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !q_full_i;

  always_comb begin
    w_ext = SIZE_W'(tex_width_i);
    h_ext = SIZE_W'(tex_height_i);
    if (w_ext < SIZE_W'(3)) begin
      w_cl = SIZE_W'(3);
    end else if (w_ext > SIZE_W'(MAX_WIDTH)) begin
      w_cl = SIZE_W'(MAX_WIDTH);
    end else begin
      w_cl = w_ext;
    end
    if (h_ext < SIZE_W'(3)) begin
      h_cl = SIZE_W'(3);
    end else if (h_ext > SIZE_W'(MAX_HEIGHT)) begin
      h_cl = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_cl = h_ext;
    end
    w_m3 = w_cl - SIZE_W'(3);
    h_m3 = h_cl - SIZE_W'(3);
    su   = 29'(u_coord_i[15:0]) * 29'(w_m3);
    sv   = 29'(v_coord_i[15:0]) * 29'(h_m3);
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q.is_sample <= (func_i == FUNC_SAMPLE);
      entry_q.texel_x   <= texel_x_i;
      entry_q.texel_y   <= texel_y_i;
      entry_q.texel_rgb <= {texel_red_i, texel_green_i, texel_blue_i};
      entry_q.iu        <= IDX_W'(su[28:16]);
      entry_q.iv        <= IDX_W'(sv[28:16]);
      entry_q.tu        <= su[15:0];
      entry_q.tv        <= sv[15:0];
      entry_q.shade     <= {shade_red_i, shade_green_i, shade_blue_i};
    end
  end

  assign entry_o = entry_q;

endmodule

/* design/tbs_back.sv */
// ----------------------------------------------------------------------------
// tbs_back: texel store and filter pipeline
// Writes texels into four banks split by column and row parity, reads the
// four neighbours of a sample in parallel, blends and modulates them.
// ----------------------------------------------------------------------------
module tbs_back
  import tbs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  entry_t                         head_i,
  output logic                           pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count_i,
  output logic                           push_o,
  output result_t                        result_o,
  output logic [$clog2(OUT_DEPTH+1)-1:0] inflight_o
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned AW  = XW + YW - 2;
  localparam int unsigned BD  = 2 ** AW;
  localparam int unsigned CNW = $clog2(OUT_DEPTH+1);

  logic [CNW-1:0] inflight_q, inflight_d;
  logic           credit_ok;
  logic [XW-1:0]  iu, iu1, wx;
  logic [YW-1:0]  iv, iv1, wy;
  logic           w_in_range;
  logic [23:0]    bank_rdata [4];

  assign credit_ok = (CNW'(inflight_q + out_count_i) < CNW'(OUT_DEPTH));
  assign pop_o     = !q_empty_i && credit_ok;

  assign iu  = head_i.iu[XW-1:0];
  assign iv  = head_i.iv[YW-1:0];
  assign iu1 = iu + 1'b1;
  assign iv1 = iv + 1'b1;
  assign wx  = XW'(IDX_W'(head_i.texel_x));
  assign wy  = YW'(IDX_W'(head_i.texel_y));
  assign w_in_range = (32'(head_i.texel_x) < MAX_WIDTH) && (32'(head_i.texel_y) < MAX_HEIGHT);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [XW-1:0] xc;
    logic [YW-1:0] yc;
    logic          we;
    assign xc = (iu[0] == b[0]) ? iu : iu1;
    assign yc = (iv[0] == b[1]) ? iv : iv1;
    assign we = pop_o && !head_i.is_sample && w_in_range &&
                (wx[0] == b[0]) && (wy[0] == b[1]);
    tbs_ram #(
      .WIDTH(24),
      .DEPTH(BD)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i({wy[YW-1:1], wx[XW-1:1]}),
      .wdata_i(head_i.texel_rgb),
      .raddr_i({yc[YW-1:1], xc[XW-1:1]}),
      .rdata_o(bank_rdata[b])
    );
  end

  // Pipeline registers.
  logic        s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  logic        s1_u0_q, s1_v0_q;
  logic [15:0] s1_tu_q, s1_tv_q;
  logic [47:0] s1_sh_q, s2_sh_q, s3_sh_q, s4_sh_q;
  logic [32:0] s2_wt_q [4];
  logic [23:0] s2_tx_q [4];
  logic [40:0] s3_p_q [3][4];
  logic [39:0] s4_bl_q [3];
  logic [35:0] s5_lo_q [3];
  logic [35:0] s5_hi_q [3];
  logic [24:0] s6_m_q [3];
  logic [24:0] s7_m_q [3];
  logic [17:0] s7_q_q [3];

  logic [16:0] wu [2];
  logic [16:0] wv [2];
  logic [33:0] wt_full [4];
  logic [23:0] tx_route [4];
  logic [41:0] bl_sum [3];
  logic [56:0] n_sum [3];
  logic [40:0] q_prod [3];
  logic [17:0] q_fix [3];
  logic [25:0] q_back [3];
  logic [15:0] q_out [3];

  always_comb begin
    wu[0] = 17'h10000 - 17'(s1_tu_q);
    wu[1] = 17'(s1_tu_q);
    wv[0] = 17'h10000 - 17'(s1_tv_q);
    wv[1] = 17'(s1_tv_q);
    for (int k = 0; k < 4; k++) begin
      wt_full[k]  = 34'(wu[k % 2]) * 34'(wv[k / 2]);
      tx_route[k] = bank_rdata[{(k / 2 == 1) ^ s1_v0_q, (k % 2 == 1) ^ s1_u0_q}];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bl_sum[c] = 42'(s3_p_q[c][0]) + 42'(s3_p_q[c][1]) +
                  42'(s3_p_q[c][2]) + 42'(s3_p_q[c][3]);
      n_sum[c]  = {s5_hi_q[c], 20'd0} + 57'(s5_lo_q[c]) + (57'd255 << 31);
      q_prod[c] = 41'(s6_m_q[c]) * 41'd32897;
      q_back[c] = 26'(s7_q_q[c]) * 26'd255;
      q_fix[c]  = (q_back[c] > 26'(s7_m_q[c])) ? s7_q_q[c] - 1'b1 : s7_q_q[c];
      q_out[c]  = (q_fix[c] > 18'd65535) ? 16'hFFFF : q_fix[c][15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      s4_v_q     <= 1'b0;
      s5_v_q     <= 1'b0;
      s6_v_q     <= 1'b0;
      s7_v_q     <= 1'b0;
      inflight_q <= '0;
    end else begin
      s1_v_q     <= pop_o && head_i.is_sample;
      s2_v_q     <= s1_v_q;
      s3_v_q     <= s2_v_q;
      s4_v_q     <= s3_v_q;
      s5_v_q     <= s4_v_q;
      s6_v_q     <= s5_v_q;
      s7_v_q     <= s6_v_q;
      inflight_q <= inflight_d;
    end
  end

  always_comb begin
    inflight_d = inflight_q;
    if ((pop_o && head_i.is_sample) && !s7_v_q) begin
      inflight_d = inflight_q + 1'b1;
    end else if (!(pop_o && head_i.is_sample) && s7_v_q) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_u0_q <= iu[0];
    s1_v0_q <= iv[0];
    s1_tu_q <= head_i.tu;
    s1_tv_q <= head_i.tv;
    s1_sh_q <= head_i.shade;
    s2_sh_q <= s1_sh_q;
    s3_sh_q <= s2_sh_q;
    s4_sh_q <= s3_sh_q;
    for (int k = 0; k < 4; k++) begin
      s2_wt_q[k] <= wt_full[k][32:0];
      s2_tx_q[k] <= tx_route[k];
    end
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        s3_p_q[c][k] <= 41'(s2_tx_q[k][23-8*c -: 8]) * 41'(s2_wt_q[k]);
      end
      s4_bl_q[c] <= bl_sum[c][39:0];
      s5_lo_q[c] <= 36'(s4_sh_q[47-16*c -: 16]) * 36'(s4_bl_q[c][19:0]);
      s5_hi_q[c] <= 36'(s4_sh_q[47-16*c -: 16]) * 36'(s4_bl_q[c][39:20]);
      s6_m_q[c]  <= n_sum[c][56:32];
      s7_m_q[c]  <= s6_m_q[c];
      s7_q_q[c]  <= q_prod[c][40:23];
    end
  end

  assign push_o         = s7_v_q;
  assign result_o.red   = q_out[0];
  assign result_o.green = q_out[1];
  assign result_o.blue  = q_out[2];
  assign inflight_o     = inflight_q;

endmodule

/* design/bilinear_texture_sampler_unit.sv */
// A sample passes the front register, the entry queue, the texel banks, the filter pipeline
// and the output queue before its result is valid at the output.
// Throughput: one transaction per cycle unless stalled, set by four banks read in parallel.
// Write transactions give no result and finish when they leave the queue.
// Reset clears all control state and sets both texture sizes to 256.
// The texel store is not cleared by reset and holds no valid data until written.
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit: bilinear texture sampler with shade modulation
// A front stage classifies transactions, a queue decouples it from the banked
// texel store and the filter pipeline, and an output queue holds results.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit
  import tbs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             func_i,
  input  logic [7:0]       texel_x_i,
  input  logic [7:0]       texel_y_i,
  input  logic [7:0]       texel_red_i,
  input  logic [7:0]       texel_green_i,
  input  logic [7:0]       texel_blue_i,
  input  logic [23:0]      u_coord_i,
  input  logic [23:0]      v_coord_i,
  input  logic [15:0]      shade_red_i,
  input  logic [15:0]      shade_green_i,
  input  logic [15:0]      shade_blue_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [15:0]      out_red_o,
  output logic [15:0]      out_green_o,
  output logic [15:0]      out_blue_o
);

  localparam int unsigned CNW = $clog2(OUT_DEPTH+1);
  localparam int unsigned QCW = $clog2(Q_DEPTH+1);

  logic [CFG_W-1:0]               tex_width_q, tex_height_q;
  logic                           f_push, q_full, q_empty, q_pop, b_push;
  logic                           o_empty, o_full, o_pop;
  entry_t                         f_entry, q_head;
  result_t                        b_result, o_result;
  logic [QCW-1:0]                 q_count;
  logic [CNW-1:0]                 o_count, inflight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= CFG_W'(256);
      tex_height_q <= CFG_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_TEX_WIDTH:  tex_width_q  <= cfg_data_i;
        CFG_TEX_HEIGHT: tex_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tbs_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .texel_x_i    (texel_x_i),
    .texel_y_i    (texel_y_i),
    .texel_red_i  (texel_red_i),
    .texel_green_i(texel_green_i),
    .texel_blue_i (texel_blue_i),
    .u_coord_i    (u_coord_i),
    .v_coord_i    (v_coord_i),
    .shade_red_i  (shade_red_i),
    .shade_green_i(shade_green_i),
    .shade_blue_i (shade_blue_i),
    .tex_width_i  (tex_width_q),
    .tex_height_i (tex_height_q),
    .q_full_i     (q_full),
    .push_o       (f_push),
    .entry_o      (f_entry)
  );

  tbs_fifo #(
    .WIDTH($bits(entry_t)),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .wdata_i(f_entry),
    .pop_i  (q_pop),
    .rdata_o(q_head),
    .empty_o(q_empty),
    .full_o (q_full),
    .count_o(q_count)
  );

  tbs_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .head_i     (q_head),
    .pop_o      (q_pop),
    .out_count_i(o_count),
    .push_o     (b_push),
    .result_o   (b_result),
    .inflight_o (inflight)
  );

  tbs_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (b_push),
    .wdata_i(b_result),
    .pop_i  (o_pop),
    .rdata_o(o_result),
    .empty_o(o_empty),
    .full_o (o_full),
    .count_o(o_count)
  );

  assign out_valid_o = !o_empty;
  assign o_pop       = out_valid_o && !out_stall_i;
  assign out_red_o   = o_result.red;
  assign out_green_o = o_result.green;
  assign out_blue_o  = o_result.blue;

  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_push |-> (!o_full || o_pop))
    else $error("Result pushed into a full output queue.");

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_push |-> (q_count != QCW'(Q_DEPTH)))
    else $error("Entry pushed into a full queue.");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNW+1)'(inflight) + (CNW+1)'(o_count) <= (CNW+1)'(OUT_DEPTH))
    else $error("Results in flight exceed output queue space.");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("Queue popped while empty.");

endmodule
